@@ rtl/cdq_pkg.sv @@
package cdq_pkg;

	// Operation requested by one input transaction.
	typedef enum logic [1:0] {
		KIND_PUSH_FRONT = 2'd0,
		KIND_PUSH_REAR  = 2'd1,
		KIND_POP_FRONT  = 2'd2,
		KIND_POP_REAR   = 2'd3
	} kind_t;

	// Outcome of one operation.
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_OVERFLOW  = 2'd1,
		STATUS_UNDERFLOW = 2'd2
	} status_t;

	// Fields of one input transaction.
	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] data_in;
	} cdq_in_t;

	// Fields of one result transaction.
	typedef struct packed {
		status_t            status;
		logic signed [31:0] front_value;
		logic signed [31:0] rear_value;
		logic        [4:0]  count;
		logic               empty_res;
		logic               full_res;
	} cdq_out_t;

	// Bookkeeping handed from the control stage to the result stage.
	typedef struct packed {
		status_t    status;
		logic [4:0] count;
		logic       empty;
		logic       full;
		logic       fwd_front;
		logic       fwd_rear;
	} cdq_tag_t;

endpackage

@@ rtl/cdq_mem.sv @@
module cdq_mem #(
	parameter int DEPTH      = 16,
	parameter int AW         = 4,
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [DATA_WIDTH-1:0] wdata,
	input  logic [AW-1:0]         raddr_front,
	input  logic [AW-1:0]         raddr_rear,
	output logic [DATA_WIDTH-1:0] rdata_front,
	output logic [DATA_WIDTH-1:0] rdata_rear
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	// One write port and two registered read ports. A read of the entry being
	// written returns the old contents; the controller forwards around that.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_front <= mem[raddr_front];
		rdata_rear  <= mem[raddr_rear];
	end

endmodule

@@ rtl/cdq_ctrl.sv @@
module cdq_ctrl #(
	parameter int DEPTH      = 16,
	parameter int AW         = 4,
	parameter int CW         = 5,
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  cdq_pkg::cdq_in_t      req,
	output logic                  busy,
	output logic                  we,
	output logic [AW-1:0]         waddr,
	output logic [DATA_WIDTH-1:0] wdata,
	output logic [AW-1:0]         raddr_front,
	output logic [AW-1:0]         raddr_rear,
	output logic                  tag_valid,
	output cdq_pkg::cdq_tag_t     tag,
	output logic [DATA_WIDTH-1:0] fwd_data
);

	import cdq_pkg::*;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
		logic [AW-1:0] r;
		if (i == AW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = i + 1'b1;
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
		logic [AW-1:0] r;
		if (i == '0) begin
			r = AW'(DEPTH - 1);
		end else begin
			r = i - 1'b1;
		end
		return r;
	endfunction

	logic                  valid_s1;
	kind_t                 kind_s1;
	logic [DATA_WIDTH-1:0] data_s1;
	logic [AW-1:0]         head_q;
	logic [AW-1:0]         tail_q;
	logic [CW-1:0]         fill_q;
	logic                  valid_s2;
	cdq_tag_t              tag_s2;
	logic [DATA_WIDTH-1:0] fwd_data_s2;

	logic [AW-1:0]         head_n;
	logic [AW-1:0]         tail_n;
	logic [CW-1:0]         fill_n;
	status_t               status_n;
	logic                  push_we;
	logic [63:0]           data_ext;
	logic                  accept;
	logic                  is_full;
	logic                  is_empty;

	assign accept   = start && !busy;
	assign busy     = valid_s1;
	assign data_ext = 64'($unsigned(req.data_in));
	assign is_full  = (fill_q == CW'(DEPTH));
	assign is_empty = (fill_q == '0);

	// Work out the new pointers, the count, the status and the slot to write.
	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		fill_n   = fill_q;
		status_n = STATUS_OK;
		push_we  = 1'b0;
		waddr    = tail_q;
		unique case (kind_s1)
			KIND_PUSH_FRONT: begin
				if (is_full) begin
					status_n = STATUS_OVERFLOW;
				end else begin
					head_n  = ring_prev(head_q);
					waddr   = ring_prev(head_q);
					push_we = 1'b1;
					fill_n  = fill_q + 1'b1;
				end
			end
			KIND_PUSH_REAR: begin
				if (is_full) begin
					status_n = STATUS_OVERFLOW;
				end else begin
					tail_n  = ring_next(tail_q);
					waddr   = tail_q;
					push_we = 1'b1;
					fill_n  = fill_q + 1'b1;
				end
			end
			KIND_POP_FRONT: begin
				if (is_empty) begin
					status_n = STATUS_UNDERFLOW;
				end else begin
					head_n = ring_next(head_q);
					fill_n = fill_q - 1'b1;
				end
			end
			KIND_POP_REAR: begin
				if (is_empty) begin
					status_n = STATUS_UNDERFLOW;
				end else begin
					tail_n = ring_prev(tail_q);
					fill_n = fill_q - 1'b1;
				end
			end
			default: begin
				status_n = STATUS_OK;
			end
		endcase
	end

	// Memory accesses for the transaction in the control stage.
	assign we          = valid_s1 && push_we;
	assign wdata       = data_s1;
	assign raddr_front = head_n;
	assign raddr_rear  = ring_prev(tail_n);

	// Input capture and pointer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			head_q   <= '0;
			tail_q   <= '0;
			fill_q   <= '0;
		end else begin
			valid_s1 <= accept;
			if (valid_s1) begin
				head_q <= head_n;
				tail_q <= tail_n;
				fill_q <= fill_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= req.kind;
			data_s1 <= data_ext[DATA_WIDTH-1:0];
		end
	end

	// Result stage bookkeeping, aligned with the registered memory reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			tag_s2.status    <= status_n;
			tag_s2.count     <= 5'(fill_n);
			tag_s2.empty     <= (fill_n == '0);
			tag_s2.full      <= (fill_n == CW'(DEPTH));
			tag_s2.fwd_front <= push_we && (waddr == raddr_front);
			tag_s2.fwd_rear  <= push_we && (waddr == raddr_rear);
			fwd_data_s2      <= data_s1;
		end
	end

	assign tag_valid = valid_s2;
	assign tag       = tag_s2;
	assign fwd_data  = fwd_data_s2;

endmodule

@@ rtl/circular_deque.sv @@
// Double-ended queue of DEPTH entries kept in a ring in a two-read, one-write
// synchronous memory. A transaction is taken when start is high and busy is
// low; its result appears on rsp two cycles later, for exactly one cycle,
// marked by done, and must be taken then since the receiver cannot stall.
// One transaction is accepted every two cycles: busy stays high for the cycle
// in which the accepted transaction moves the pointers and addresses the memory.
// A push into a full deque is dropped with overflow status, a pop from an
// empty deque is ignored with underflow status, and front and rear values
// read zero when empty.
module circular_deque #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cdq_pkg::cdq_in_t  req,
	output logic              busy,
	output logic              done,
	output cdq_pkg::cdq_out_t rsp
);

	import cdq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic                  we;
	logic [AW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic [AW-1:0]         raddr_front;
	logic [AW-1:0]         raddr_rear;
	logic [DATA_WIDTH-1:0] rdata_front;
	logic [DATA_WIDTH-1:0] rdata_rear;
	logic                  tag_valid;
	cdq_tag_t              tag;
	logic [DATA_WIDTH-1:0] fwd_data;
	logic [DATA_WIDTH-1:0] front_raw;
	logic [DATA_WIDTH-1:0] rear_raw;
	logic [63:0]           front_ext;
	logic [63:0]           rear_ext;

	cdq_ctrl #(
		.DEPTH      (DEPTH),
		.AW         (AW),
		.CW         (CW),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req         (req),
		.busy        (busy),
		.we          (we),
		.waddr       (waddr),
		.wdata       (wdata),
		.raddr_front (raddr_front),
		.raddr_rear  (raddr_rear),
		.tag_valid   (tag_valid),
		.tag         (tag),
		.fwd_data    (fwd_data)
	);

	cdq_mem #(
		.DEPTH      (DEPTH),
		.AW         (AW),
		.DATA_WIDTH (DATA_WIDTH)
	) u_mem (
		.clk         (clk),
		.we          (we),
		.waddr       (waddr),
		.wdata       (wdata),
		.raddr_front (raddr_front),
		.raddr_rear  (raddr_rear),
		.rdata_front (rdata_front),
		.rdata_rear  (rdata_rear)
	);

	// Take the freshly written value where the read hit the entry being written.
	assign front_raw = tag.fwd_front ? fwd_data : rdata_front;
	assign rear_raw  = tag.fwd_rear ? fwd_data : rdata_rear;
	assign front_ext = tag.empty ? 64'd0 : 64'(front_raw);
	assign rear_ext  = tag.empty ? 64'd0 : 64'(rear_raw);

	// Result transaction.
	assign done            = tag_valid;
	assign rsp.status      = tag.status;
	assign rsp.front_value = $signed(front_ext[31:0]);
	assign rsp.rear_value  = $signed(rear_ext[31:0]);
	assign rsp.count       = tag.count;
	assign rsp.empty_res   = tag.empty;
	assign rsp.full_res    = tag.full;

	// Every accepted transaction yields its result on done after the control and result stages.
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("result missing two cycles after acceptance");

	// The empty flag agrees with the reported count.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.empty_res == (rsp.count == 5'd0)))
		else $error("empty flag disagrees with count");

	// An empty deque shows zero at both ends.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.empty_res) |-> (rsp.front_value == 32'sd0 && rsp.rear_value == 32'sd0))
		else $error("non-zero end value on empty deque");

	// Overflow only happens on a full deque.
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == STATUS_OVERFLOW) |-> rsp.full_res)
		else $error("overflow reported while not full");

endmodule
